@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int BIT_CNT_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_PHASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_PHASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd2;

    localparam logic [CFG_W-1:0] BIT_PHASE_RST   = 8'd2;
    localparam logic [CFG_W-1:0] EDGE_PHASE_RST  = 8'd4;
    localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST = 8'd250;

    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
    localparam logic [OP_W-1:0] OP_START    = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP     = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ     = 3'd4;
    localparam logic [OP_W-1:0] OP_WAIT_ACK = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2,
        PH_WR_D, PH_WR_H, PH_WR_L, PH_RD_L, PH_RD_H,
        PH_AK_L, PH_AK_H, PH_WA_L, PH_WA_H, PH_WA_P
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] bit_phase_ticks;
        logic [CFG_W-1:0] edge_phase_ticks;
        logic [CFG_W-1:0] ack_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              sda_in;
    } tick_in_t;

    typedef struct packed {
        logic              ack_missed;
        logic [BYTE_W-1:0] rx_byte;
        logic              done_res;
        logic              busy_res;
        logic              sda_drive;
        logic              sda_level;
        logic              scl_level;
    } tick_out_t;

endpackage

@@ rtl/i2cm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// i2cm_cfg_regs
// Timing configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module i2cm_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [i2cm_pkg::CFG_W-1:0]       cfg_wdata,
    output i2cm_pkg::cfg_t                   cfg
);

    i2cm_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_phase_ticks   <= i2cm_pkg::BIT_PHASE_RST;
            cfg_reg.edge_phase_ticks  <= i2cm_pkg::EDGE_PHASE_RST;
            cfg_reg.ack_timeout_ticks <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                i2cm_pkg::REG_BIT_PHASE:   cfg_reg.bit_phase_ticks   <= cfg_wdata;
                i2cm_pkg::REG_EDGE_PHASE:  cfg_reg.edge_phase_ticks  <= cfg_wdata;
                i2cm_pkg::REG_ACK_TIMEOUT: cfg_reg.ack_timeout_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/i2cm_phase_engine.sv @@
// ----------------------------------------------------------------------------
// i2cm_phase_engine
// Bus phase sequencer: one tick per enable, SCL/SDA levels and status.
// ----------------------------------------------------------------------------
module i2cm_phase_engine #(
    parameter int TICK_COUNTER_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  i2cm_pkg::cfg_t        cfg,
    input  i2cm_pkg::tick_in_t    tick_in,
    output i2cm_pkg::tick_out_t   tick_out
);

    localparam int TW    = TICK_COUNTER_BITS;
    localparam int CMP_W = (TW > i2cm_pkg::CFG_W) ? TW : i2cm_pkg::CFG_W;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    i2cm_pkg::phase_t                    phase_reg, phase_next;
    logic [TW-1:0]                       tick_reg, tick_next;
    logic [i2cm_pkg::BIT_CNT_W-1:0]      bit_reg, bit_next;
    logic [i2cm_pkg::BYTE_W-1:0]         shift_reg, shift_next;
    logic [i2cm_pkg::BYTE_W-1:0]         rx_reg, rx_next;
    logic                                ack_mode_reg, ack_mode_next;
    logic                                scl_reg, scl_next;
    logic                                sda_reg, sda_next;
    logic                                drive_reg, drive_next;
    logic                                missed_reg, missed_next;
    logic                                done;

    logic [TW-1:0]                       tick_inc;
    logic [i2cm_pkg::CFG_W-1:0]          len_raw;
    logic [CMP_W-1:0]                    len_ext;
    logic [CMP_W-1:0]                    inc_ext;
    logic [CMP_W-1:0]                    tick_ext;
    logic [CMP_W-1:0]                    tmo_ext;
    logic                                phase_end;
    logic                                timed_out;
    logic [i2cm_pkg::BIT_CNT_W-1:0]      bit_inc;
    logic [i2cm_pkg::BYTE_W-1:0]         shift_wr;

    always_comb begin
        tick_inc = (tick_reg == TMAX) ? TMAX : tick_reg + 1'b1;
        if (phase_reg == i2cm_pkg::PH_ST1 || phase_reg == i2cm_pkg::PH_ST2 ||
            phase_reg == i2cm_pkg::PH_SP1 || phase_reg == i2cm_pkg::PH_SP2) begin
            len_raw = cfg.edge_phase_ticks;
        end else begin
            len_raw = cfg.bit_phase_ticks;
        end
        if (len_raw == '0) begin
            len_raw = {{(i2cm_pkg::CFG_W-1){1'b0}}, 1'b1};
        end
        len_ext   = CMP_W'(len_raw);
        inc_ext   = CMP_W'(tick_inc);
        tick_ext  = CMP_W'(tick_reg);
        tmo_ext   = CMP_W'(cfg.ack_timeout_ticks);
        phase_end = !((inc_ext < len_ext) && (tick_inc != TMAX));
        timed_out = (tick_ext >= tmo_ext) || (tick_reg == TMAX);
        bit_inc   = bit_reg + 1'b1;
        shift_wr  = {shift_reg[i2cm_pkg::BYTE_W-2:0], 1'b0};
    end

    always_comb begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        rx_next       = rx_reg;
        ack_mode_next = ack_mode_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        drive_next    = drive_reg;
        missed_next   = missed_reg;
        done          = 1'b0;

        if (phase_reg == i2cm_pkg::PH_IDLE) begin
            tick_next = '0;
            bit_next  = '0;
            case (tick_in.op)
                i2cm_pkg::OP_START: begin
                    drive_next = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_ST1;
                end
                i2cm_pkg::OP_STOP: begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_SP1;
                end
                i2cm_pkg::OP_WRITE: begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    shift_next = tick_in.tx_byte;
                    sda_next   = tick_in.tx_byte[i2cm_pkg::BYTE_W-1];
                    phase_next = i2cm_pkg::PH_WR_D;
                end
                i2cm_pkg::OP_READ: begin
                    drive_next    = 1'b0;
                    scl_next      = 1'b0;
                    shift_next    = '0;
                    ack_mode_next = tick_in.send_ack;
                    phase_next    = i2cm_pkg::PH_RD_L;
                end
                i2cm_pkg::OP_WAIT_ACK: begin
                    drive_next  = 1'b0;
                    sda_next    = 1'b1;
                    missed_next = 1'b0;
                    phase_next  = i2cm_pkg::PH_WA_L;
                end
                default: ;
            endcase
        end else if (phase_reg == i2cm_pkg::PH_WA_P) begin
            if (!tick_in.sda_in) begin
                scl_next    = 1'b0;
                missed_next = 1'b0;
                phase_next  = i2cm_pkg::PH_IDLE;
                done        = 1'b1;
            end else if (timed_out) begin
                // timeout: flag it and issue a stop condition
                missed_next = 1'b1;
                drive_next  = 1'b1;
                scl_next    = 1'b0;
                sda_next    = 1'b0;
                phase_next  = i2cm_pkg::PH_SP1;
                tick_next   = '0;
            end else begin
                tick_next = tick_reg + 1'b1;
            end
        end else if (!phase_end) begin
            tick_next = tick_inc;
        end else begin
            tick_next = '0;
            unique case (phase_reg)
                i2cm_pkg::PH_ST1: begin
                    sda_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_ST2;
                end
                i2cm_pkg::PH_ST2: begin
                    scl_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                i2cm_pkg::PH_SP1: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_SP2;
                end
                i2cm_pkg::PH_SP2: begin
                    phase_next = i2cm_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                i2cm_pkg::PH_WR_D: begin
                    scl_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_WR_H;
                end
                i2cm_pkg::PH_WR_H: begin
                    scl_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_WR_L;
                end
                i2cm_pkg::PH_WR_L: begin
                    bit_next = bit_inc;
                    if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                        phase_next = i2cm_pkg::PH_IDLE;
                        done       = 1'b1;
                    end else begin
                        shift_next = shift_wr;
                        sda_next   = shift_wr[i2cm_pkg::BYTE_W-1];
                        phase_next = i2cm_pkg::PH_WR_D;
                    end
                end
                i2cm_pkg::PH_RD_L: begin
                    scl_next   = 1'b1;
                    shift_next = {shift_reg[i2cm_pkg::BYTE_W-2:0], tick_in.sda_in};
                    phase_next = i2cm_pkg::PH_RD_H;
                end
                i2cm_pkg::PH_RD_H: begin
                    bit_next = bit_inc;
                    scl_next = 1'b0;
                    if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                        rx_next    = shift_reg;
                        drive_next = 1'b1;
                        sda_next   = !ack_mode_reg;
                        phase_next = i2cm_pkg::PH_AK_L;
                    end else begin
                        phase_next = i2cm_pkg::PH_RD_L;
                    end
                end
                i2cm_pkg::PH_AK_L: begin
                    scl_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_AK_H;
                end
                i2cm_pkg::PH_AK_H: begin
                    scl_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                i2cm_pkg::PH_WA_L: begin
                    scl_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_WA_H;
                end
                i2cm_pkg::PH_WA_H: begin
                    phase_next = i2cm_pkg::PH_WA_P;
                end
                default: begin
                    phase_next = i2cm_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= i2cm_pkg::PH_IDLE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            rx_reg       <= '0;
            ack_mode_reg <= 1'b0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            drive_reg    <= 1'b1;
            missed_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            rx_reg       <= rx_next;
            ack_mode_reg <= ack_mode_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            drive_reg    <= drive_next;
            missed_reg   <= missed_next;
        end
    end

    always_comb begin
        tick_out.scl_level  = scl_next;
        tick_out.sda_level  = sda_next;
        tick_out.sda_drive  = drive_next;
        tick_out.busy_res   = (phase_next != i2cm_pkg::PH_IDLE);
        tick_out.done_res   = done;
        tick_out.rx_byte    = rx_next;
        tick_out.ack_missed = missed_next;
    end

endmodule

@@ rtl/i2c_master_bit_engine_core.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// I2C master bit engine: start, stop, byte write, byte read with ACK/NACK
// and ACK wait with timeout, driven one bus tick per input transfer.
//
// Input stream (s_*): one transfer per bus tick. s_tuser carries the command
// code, s_tdata the byte to send, the ACK choice and the sampled SDA level.
// Commands arriving while a command is running are ignored.
// Output stream (m_*): exactly one transfer per input transfer, carrying the
// line levels, busy/done status, last received byte and the ACK-missed flag
// as they stand after that tick.
// A result is registered on its way out: input register, then result
// register. Throughput: one transfer per cycle while the result is taken;
// the phase sequencer updates once per tick.
// A stalled m_tready holds the result; one more input transfer is buffered,
// then s_tready drops until the result is taken.
// Configuration writes (cfg_we/cfg_addr/cfg_wdata) take effect at once; the
// user must make them while the engine is idle, the block does not enforce it.
// Reset (aresetn low, synchronous): both streams empty, engine idle, SCL and
// SDA driven high, timing registers back to 2/4/250 ticks.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core #(
    parameter int TICK_COUNTER_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [i2cm_pkg::CFG_W-1:0]       cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,  // tx_byte[7:0], send_ack[8], sda_in[9]
    input  logic [2:0]                       s_tuser,  // op[2:0]
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata   // scl_level[0], sda_level[1],
                                                       // sda_drive[2], busy_res[3],
                                                       // done_res[4], rx_byte[12:5],
                                                       // ack_missed[13]
);

    i2cm_pkg::cfg_t      cfg;
    i2cm_pkg::tick_in_t  in_item_reg;
    i2cm_pkg::tick_out_t tick_out;
    i2cm_pkg::tick_out_t out_item_reg;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                step_en;

    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.op       <= s_tuser;
            in_item_reg.tx_byte  <= s_tdata[7:0];
            in_item_reg.send_ack <= s_tdata[8];
            in_item_reg.sda_in   <= s_tdata[9];
        end
    end

    i2cm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    i2cm_phase_engine #(
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .cfg      (cfg),
        .tick_in  (in_item_reg),
        .tick_out (tick_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_item_reg <= tick_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_item_reg};

    a_hold_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step_en |=> in_valid_reg)
        else $error("pending input transfer dropped");

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a result stall");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && tick_out.done_res |-> !tick_out.busy_res)
        else $error("done raised while still busy");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg && !in_valid_reg)
        else $error("stream registers not empty after reset");

endmodule
